>>> design/mps_pkg.sv
// Shared types, codes and arithmetic helpers for the phi-four Metropolis site update.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;

    localparam int SITES_DEFAULT         = 1024;
    localparam int MAX_NEIGHBORS_DEFAULT = 8;
    localparam int SITE_ADDR_MAX_W       = 16;
    localparam int NBR_ADDR_MAX_W        = 21;
    localparam int CNT_MAX_W             = 6;
    localparam int PADDR_W               = 4;
    localparam int PDATA_W               = 32;
    localparam int MUL_W                 = 34;
    localparam int PROD_W                = 2 * MUL_W;

    typedef enum logic [1:0] {
        FUNC_FIELD    = 2'd0,
        FUNC_NEIGHBOR = 2'd1,
        FUNC_INFO     = 2'd2,
        FUNC_UPDATE   = 2'd3
    } mps_func_t;

    typedef enum logic [1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_MASS_SQUARED = 2'd1,
        REG_COUPLING     = 2'd2
    } mps_reg_t;

    typedef struct packed {
        mps_func_t          func;
        logic [9:0]         site;
        logic [2:0]         slot;
        logic [9:0]         neighbor_site;
        logic [3:0]         neighbor_count;
        logic [15:0]        weight;
        logic signed [23:0] field_value;
        logic signed [15:0] proposal_random;
        logic [15:0]        accept_random;
    } mps_cmd_t;

    typedef struct packed {
        logic [9:0]         updated_site;
        logic               accepted;
        logic signed [23:0] new_value;
    } mps_result_t;

    typedef struct packed {
        logic [15:0]        step_size;
        logic signed [23:0] mass_squared;
        logic [22:0]        coupling;
    } mps_cfg_t;

    typedef struct packed {
        logic                      site_re;
        logic                      field_we;
        logic                      info_we;
        logic [SITE_ADDR_MAX_W-1:0] site_addr;
        logic signed [23:0]        field_wdata;
        logic [CNT_MAX_W-1:0]      info_count;
        logic [15:0]               info_weight;
        logic                      nbr_re;
        logic                      nbr_we;
        logic [NBR_ADDR_MAX_W-1:0] nbr_addr;
        logic [9:0]                nbr_index;
        logic [15:0]               nbr_weight;
    } mps_mem_req_t;

    typedef struct packed {
        logic                 clearing;
        logic signed [23:0]   field;
        logic [CNT_MAX_W-1:0] count;
        logic [15:0]          site_weight;
        logic [9:0]           nbr_index;
        logic [15:0]          nbr_weight;
    } mps_mem_rsp_t;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
                                                       input logic [5:0] s);
        logic signed [PROD_W-1:0] half;
        begin
            half = 68'sd1 <<< (s - 6'd1);
            return (v + half) >>> s;
        end
    endfunction

    // floor(2^32 / k) for k = 1..9
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] m;
        begin
            unique case (k)
                4'd1:    m = 33'h1_0000_0000;
                4'd2:    m = 33'h0_8000_0000;
                4'd3:    m = 33'd1431655765;
                4'd4:    m = 33'h0_4000_0000;
                4'd5:    m = 33'd858993459;
                4'd6:    m = 33'd715827882;
                4'd7:    m = 33'd613566756;
                4'd8:    m = 33'h0_2000_0000;
                4'd9:    m = 33'd477218588;
                default: m = 33'd0;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/mps_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mps_mul
    import mps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

endmodule
`default_nettype wire

>>> design/mps_regs.sv
// APB configuration registers: step size, mass squared, coupling.
// Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mps_regs
    import mps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    output mps_cfg_t                cfg
);

    logic [15:0]        step_size_reg;
    logic signed [23:0] mass_squared_reg;
    logic [22:0]        coupling_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg    <= 16'd2048;
            mass_squared_reg <= '0;
            coupling_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_STEP_SIZE:    step_size_reg    <= pwdata[15:0];
                REG_MASS_SQUARED: mass_squared_reg <= pwdata[23:0];
                REG_COUPLING:     coupling_reg     <= pwdata[22:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_STEP_SIZE:    prdata = {16'd0, step_size_reg};
            REG_MASS_SQUARED: prdata = {{8{mass_squared_reg[23]}}, mass_squared_reg};
            REG_COUPLING:     prdata = {9'd0, coupling_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.step_size    = step_size_reg;
    assign cfg.mass_squared = mass_squared_reg;
    assign cfg.coupling     = coupling_reg;

endmodule
`default_nettype wire

>>> design/mps_store.sv
// Site memory (field, neighbor count, site weight) and neighbor memory (index, link weight),
// with the clearing pass over the site memory after reset. Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mps_store
    import mps_pkg::*;
#(
    parameter int SITES         = SITES_DEFAULT,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mps_mem_req_t req,
    output mps_mem_rsp_t      rsp
);

    localparam int SITE_AW   = $clog2(SITES);
    localparam int NBR_DEPTH = SITES * MAX_NEIGHBORS;
    localparam int NBR_AW    = $clog2(NBR_DEPTH);
    localparam int CNT_W     = $clog2(MAX_NEIGHBORS + 1);
    localparam int W_LO      = 0;
    localparam int C_LO      = 16;
    localparam int F_LO      = 16 + CNT_W;
    localparam int SITE_EW   = 24 + CNT_W + 16;

    logic [SITE_EW-1:0] site_mem [SITES];
    logic [25:0]        nbr_mem  [NBR_DEPTH];
    logic [SITE_EW-1:0] site_rdata_reg;
    logic [25:0]        nbr_rdata_reg;
    logic [SITE_AW-1:0] clr_addr_reg;
    logic               clearing_reg;
    logic [SITE_AW-1:0] site_a;
    logic [NBR_AW-1:0]  nbr_a;

    assign site_a = req.site_addr[SITE_AW-1:0];
    assign nbr_a  = req.nbr_addr[NBR_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SITE_AW'(SITES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            site_mem[clr_addr_reg] <= '0;
        end
        else
        begin
            if (req.field_we)
            begin
                site_mem[site_a][F_LO +: 24] <= req.field_wdata;
            end
            if (req.info_we)
            begin
                site_mem[site_a][C_LO +: CNT_W] <= req.info_count[CNT_W-1:0];
                site_mem[site_a][W_LO +: 16]    <= req.info_weight;
            end
        end
        if (req.site_re)
        begin
            site_rdata_reg <= site_mem[site_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.nbr_we)
        begin
            nbr_mem[nbr_a] <= {req.nbr_index, req.nbr_weight};
        end
        if (req.nbr_re)
        begin
            nbr_rdata_reg <= nbr_mem[nbr_a];
        end
    end

    assign rsp.clearing    = clearing_reg;
    assign rsp.field       = site_rdata_reg[F_LO +: 24];
    assign rsp.count       = CNT_MAX_W'(site_rdata_reg[C_LO +: CNT_W]);
    assign rsp.site_weight = site_rdata_reg[W_LO +: 16];
    assign rsp.nbr_index   = nbr_rdata_reg[25:16];
    assign rsp.nbr_weight  = nbr_rdata_reg[15:0];

endmodule
`default_nettype wire

>>> design/mps_core.sv
// Command sequencer and datapath: loads, proposal, action change over neighbors, exp test,
// write-back. Uses mps_mul and drives mps_store. Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mps_core
    import mps_pkg::*;
#(
    parameter int SITES         = SITES_DEFAULT,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire mps_cmd_t     cmd,
    input  wire mps_cfg_t     cfg,
    output logic              done,
    output mps_result_t       result,
    output mps_mem_req_t      req,
    input  wire mps_mem_rsp_t rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_OLD, S_PROP, S_O2, S_N2, S_O4, S_N4,
        S_NB_RD, S_NB_WT, S_NB_PHI, S_KIN1, S_KIN2M, S_KIN2,
        S_MASS_M, S_MASS, S_CPL_LO, S_CPL_HI, S_SW_M, S_SWL, S_SWH, S_DECIDE,
        S_EX_M, S_EX_P, S_EX_QM, S_EX_Q, S_EX_C, S_SQ_M, S_SQ, S_CMP, S_WB
    } state_t;

    state_t                     state_reg;
    logic                       done_reg;
    mps_result_t                result_reg;
    logic [9:0]                 site_reg;
    logic signed [15:0]         prop_reg;
    logic [15:0]                urand_reg;
    logic [NBR_ADDR_MAX_W-1:0]  base_reg;
    logic [CNT_MAX_W-1:0]       nidx_reg;
    logic [CNT_MAX_W-1:0]       count_reg;
    logic [15:0]                sw_reg;
    logic signed [23:0]         phi_old_reg;
    logic signed [23:0]         phi_new_reg;
    logic signed [24:0]         dphi_reg;
    logic signed [29:0]         o2_reg;
    logic signed [29:0]         n2_reg;
    logic signed [29:0]         dphi2_reg;
    logic signed [39:0]         o4_reg;
    logic signed [39:0]         dphi4_reg;
    logic signed [30:0]         t_reg;
    logic [15:0]                w_reg;
    logic                       nbok_reg;
    logic signed [51:0]         acc_reg;
    logic signed [45:0]         brk_reg;
    logic signed [43:0]         part_reg;
    logic [29:0]                y_reg;
    logic [30:0]                r_reg;
    logic [30:0]                p_reg;
    logic [30:0]                q0_reg;
    logic [3:0]                 k_reg;
    logic [1:0]                 sq_cnt_reg;
    logic                       accept_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       site_ok;
    logic                       slot_ok;
    logic                       nb_ok;
    logic                       accept_cmd;
    logic signed [25:0]         psum;
    logic signed [PROD_W-1:0]   rs9;
    logic [34:0]                qk;
    logic [34:0]                rem;
    logic [30:0]                q_fix;
    logic signed [23:0]         phin;

    mps_mul u_mul
    (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    assign site_ok    = 32'(cmd.site) < SITES;
    assign slot_ok    = 32'(cmd.slot) < MAX_NEIGHBORS;
    assign nb_ok      = 32'(rsp.nbr_index) < SITES;
    assign accept_cmd = start && !busy;
    assign busy       = rsp.clearing || (state_reg != S_IDLE);
    assign done       = done_reg;
    assign result     = result_reg;

    assign rs9   = rshr(prod_reg, 6'd9);
    assign psum  = 26'(phi_old_reg) + rs9[25:0];
    assign qk    = 35'(q0_reg) * 35'(k_reg);
    assign rem   = 35'(p_reg) - qk;
    assign q_fix = q0_reg + 31'(rem >= 35'(k_reg));
    assign phin  = nbok_reg ? rsp.field : 24'sd0;

    always_comb
    begin
        req             = '0;
        req.site_addr   = SITE_ADDR_MAX_W'(cmd.site);
        req.field_wdata = cmd.field_value;
        req.info_count  = (32'(cmd.neighbor_count) > MAX_NEIGHBORS) ?
                          CNT_MAX_W'(MAX_NEIGHBORS) : CNT_MAX_W'(cmd.neighbor_count);
        req.info_weight = cmd.weight;
        req.nbr_addr    = NBR_ADDR_MAX_W'(32'(cmd.site) * MAX_NEIGHBORS + 32'(cmd.slot));
        req.nbr_index   = cmd.neighbor_site;
        req.nbr_weight  = cmd.weight;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_cmd && site_ok)
                begin
                    unique case (cmd.func)
                        FUNC_FIELD:    req.field_we = 1'b1;
                        FUNC_NEIGHBOR: req.nbr_we   = slot_ok;
                        FUNC_INFO:     req.info_we  = 1'b1;
                        FUNC_UPDATE:   req.site_re  = 1'b1;
                    endcase
                end
            end
            S_NB_RD:
            begin
                req.nbr_re   = nidx_reg < count_reg;
                req.nbr_addr = base_reg + NBR_ADDR_MAX_W'(nidx_reg);
            end
            S_NB_WT:
            begin
                req.site_re   = nb_ok;
                req.site_addr = SITE_ADDR_MAX_W'(rsp.nbr_index);
            end
            S_WB:
            begin
                req.field_we    = accept_reg;
                req.site_addr   = SITE_ADDR_MAX_W'(site_reg);
                req.field_wdata = phi_new_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_OLD:
            begin
                mul_a = MUL_W'(prop_reg);
                mul_b = {18'd0, cfg.step_size};
            end
            S_PROP:
            begin
                mul_a = MUL_W'(phi_old_reg);
                mul_b = MUL_W'(phi_old_reg);
            end
            S_O2:
            begin
                mul_a = MUL_W'(phi_new_reg);
                mul_b = MUL_W'(phi_new_reg);
            end
            S_N2:
            begin
                mul_a = MUL_W'(o2_reg);
                mul_b = MUL_W'(o2_reg);
            end
            S_O4:
            begin
                mul_a = MUL_W'(n2_reg);
                mul_b = MUL_W'(n2_reg);
            end
            S_NB_PHI:
            begin
                mul_a = MUL_W'(phin);
                mul_b = MUL_W'(dphi_reg);
            end
            S_KIN1:
            begin
                mul_a = MUL_W'(dphi2_reg);
                mul_b = {18'd0, w_reg};
            end
            S_KIN2M:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = {18'd0, w_reg};
            end
            S_MASS_M:
            begin
                mul_a = MUL_W'(cfg.mass_squared);
                mul_b = MUL_W'(dphi2_reg);
            end
            S_MASS:
            begin
                mul_a = {11'd0, cfg.coupling};
                mul_b = {14'd0, dphi4_reg[19:0]};
            end
            S_CPL_LO:
            begin
                mul_a = {11'd0, cfg.coupling};
                mul_b = MUL_W'($signed(dphi4_reg[39:20]));
            end
            S_SW_M:
            begin
                mul_a = {14'd0, brk_reg[19:0]};
                mul_b = {18'd0, sw_reg};
            end
            S_SWL:
            begin
                mul_a = MUL_W'($signed(brk_reg[45:20]));
                mul_b = {18'd0, sw_reg};
            end
            S_EX_M:
            begin
                mul_a = {4'd0, y_reg};
                mul_b = {3'd0, r_reg};
            end
            S_EX_QM:
            begin
                mul_a = {3'd0, p_reg};
                mul_b = {1'b0, recip(k_reg)};
            end
            S_SQ_M:
            begin
                mul_a = {3'd0, r_reg};
                mul_b = {3'd0, r_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_cmd && site_ok && cmd.func == FUNC_UPDATE)
                    begin
                        site_reg  <= cmd.site;
                        prop_reg  <= cmd.proposal_random;
                        urand_reg <= cmd.accept_random;
                        base_reg  <= NBR_ADDR_MAX_W'(32'(cmd.site) * MAX_NEIGHBORS);
                        nidx_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_OLD;
                    end
                end
                S_OLD:
                begin
                    phi_old_reg <= rsp.field;
                    count_reg   <= rsp.count;
                    sw_reg      <= rsp.site_weight;
                    state_reg   <= S_PROP;
                end
                S_PROP:
                begin
                    if (psum > 26'sd8388607)
                    begin
                        phi_new_reg <= 24'sd8388607;
                    end
                    else if (psum < -26'sd8388607)
                    begin
                        phi_new_reg <= -24'sd8388607;
                    end
                    else
                    begin
                        phi_new_reg <= 24'(psum);
                    end
                    state_reg <= S_O2;
                end
                S_O2:
                begin
                    o2_reg    <= 30'(rshr(prod_reg, 6'd18));
                    dphi_reg  <= 25'(phi_new_reg) - 25'(phi_old_reg);
                    state_reg <= S_N2;
                end
                S_N2:
                begin
                    n2_reg    <= 30'(rshr(prod_reg, 6'd18));
                    dphi2_reg <= 30'(rshr(prod_reg, 6'd18)) - o2_reg;
                    state_reg <= S_O4;
                end
                S_O4:
                begin
                    o4_reg    <= 40'(rshr(prod_reg, 6'd18));
                    state_reg <= S_N4;
                end
                S_N4:
                begin
                    dphi4_reg <= 40'(rshr(prod_reg, 6'd18)) - o4_reg;
                    state_reg <= S_NB_RD;
                end
                S_NB_RD:
                begin
                    state_reg <= (nidx_reg < count_reg) ? S_NB_WT : S_MASS_M;
                end
                S_NB_WT:
                begin
                    w_reg     <= rsp.nbr_weight;
                    nbok_reg  <= nb_ok;
                    state_reg <= S_NB_PHI;
                end
                S_NB_PHI:
                begin
                    state_reg <= S_KIN1;
                end
                S_KIN1:
                begin
                    t_reg     <= 31'(rshr(prod_reg, 6'd18));
                    state_reg <= S_KIN2M;
                end
                S_KIN2M:
                begin
                    acc_reg   <= acc_reg + 52'(rshr(prod_reg, 6'd13));
                    state_reg <= S_KIN2;
                end
                S_KIN2:
                begin
                    acc_reg   <= acc_reg - 52'(rshr(prod_reg, 6'd12));
                    nidx_reg  <= nidx_reg + 1'b1;
                    state_reg <= S_NB_RD;
                end
                S_MASS_M:
                begin
                    state_reg <= S_MASS;
                end
                S_MASS:
                begin
                    brk_reg   <= -46'(rshr(prod_reg, 6'd19));
                    state_reg <= S_CPL_LO;
                end
                S_CPL_LO:
                begin
                    part_reg  <= 44'(prod_reg);
                    state_reg <= S_CPL_HI;
                end
                S_CPL_HI:
                begin
                    brk_reg   <= brk_reg
                                 + 46'(rshr((prod_reg <<< 20) + PROD_W'(part_reg), 6'd18));
                    state_reg <= S_SW_M;
                end
                S_SW_M:
                begin
                    state_reg <= S_SWL;
                end
                S_SWL:
                begin
                    part_reg  <= 44'(prod_reg);
                    state_reg <= S_SWH;
                end
                S_SWH:
                begin
                    acc_reg   <= acc_reg
                                 + 52'(rshr((prod_reg <<< 20) + PROD_W'(part_reg), 6'd12));
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    y_reg <= {acc_reg[21:0], 8'd0};
                    r_reg <= 31'h4000_0000;
                    k_reg <= 4'd9;
                    priority if (acc_reg <= 52'sd0)
                    begin
                        accept_reg <= 1'b1;
                        state_reg  <= S_WB;
                    end
                    else if (acc_reg >= 52'sd4194304)
                    begin
                        accept_reg <= 1'b0;
                        state_reg  <= S_WB;
                    end
                    else
                    begin
                        state_reg <= S_EX_M;
                    end
                end
                S_EX_M:
                begin
                    state_reg <= S_EX_P;
                end
                S_EX_P:
                begin
                    p_reg     <= prod_reg[60:30];
                    state_reg <= S_EX_QM;
                end
                S_EX_QM:
                begin
                    state_reg <= S_EX_Q;
                end
                S_EX_Q:
                begin
                    q0_reg    <= prod_reg[62:32];
                    state_reg <= S_EX_C;
                end
                S_EX_C:
                begin
                    r_reg <= 31'h4000_0000 - q_fix;
                    k_reg <= k_reg - 1'b1;
                    if (k_reg == 4'd1)
                    begin
                        sq_cnt_reg <= '0;
                        state_reg  <= S_SQ_M;
                    end
                    else
                    begin
                        state_reg <= S_EX_M;
                    end
                end
                S_SQ_M:
                begin
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    r_reg      <= prod_reg[60:30];
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    state_reg  <= (sq_cnt_reg == 2'd3) ? S_CMP : S_SQ_M;
                end
                S_CMP:
                begin
                    accept_reg <= {1'b0, urand_reg, 14'd0} < r_reg;
                    state_reg  <= S_WB;
                end
                S_WB:
                begin
                    done_reg                <= 1'b1;
                    result_reg.updated_site <= site_reg;
                    result_reg.accepted     <= accept_reg;
                    result_reg.new_value    <= accept_reg ? phi_new_reg : phi_old_reg;
                    state_reg               <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/metropolis_phi4_site_update_top.sv
// Top level of the phi-four Metropolis site update: registers, store, sequencer.
// Depends on mps_pkg, mps_regs, mps_store, mps_core.
//
//  channel   handshake                        payload
//  command   start, busy (accept: start&!busy) cmd    (mps_cmd_t)
//  result    done (one-cycle strobe)           result (mps_result_t)
//  config    psel/penable/pwrite/pready (APB)  paddr, pwdata, prdata
//
// An update keeps busy high until its write-back, including the exp(-x) evaluation when it runs;
// done pulses in the same cycle as busy falls.
// One shared 34x34 multiplier and the single port of each memory serve the whole update.
// After reset busy stays high while the site memory is cleared.
// The result cannot be stalled: done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module metropolis_phi4_site_update_top
    import mps_pkg::*;
#(
    parameter int SITES         = SITES_DEFAULT,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mps_cmd_t           cmd,
    output logic                    done,
    output mps_result_t             result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    mps_cfg_t     cfg;
    mps_mem_req_t req;
    mps_mem_rsp_t rsp;

    mps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mps_store #(
        .SITES         (SITES),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    mps_core #(
        .SITES         (SITES),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .cfg    (cfg),
        .done   (done),
        .result (result),
        .req    (req),
        .rsp    (rsp)
    );

endmodule
`default_nettype wire

>>> design/mps_checker.sv
// Port-level checks on command and result transfers, bound to the top level.
// Depends on mps_pkg and metropolis_phi4_site_update_top.
`timescale 1ns / 1ps
`default_nettype none
module mps_port_checks
    import mps_pkg::*;
#(
    parameter int SITES = SITES_DEFAULT
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire mps_cmd_t    cmd,
    input wire logic        done,
    input wire mps_result_t result
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == FUNC_UPDATE && 32'(cmd.site) < SITES) |=> busy)
        else $error("update transfer did not raise busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && $past(cmd.func) == FUNC_UPDATE))
        else $error("busy raised without an update transfer");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("result transfer carries unknown bits");

endmodule

bind metropolis_phi4_site_update_top mps_port_checks #(.SITES(SITES)) u_mps_port_checks
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
`default_nettype wire
